// File: hw/rtl/pco_tlv_pkg.sv
// ----------------------------------------------------------------------------
// pco_tlv_pkg
// Shared types, identifier constants and decode helpers for the PCO item
// parser.
// ----------------------------------------------------------------------------
package pco_tlv_pkg;

	// Configuration protocol identifiers (always one-octet length)
	localparam logic [15:0] ID_LCP  = 16'hC021;
	localparam logic [15:0] ID_PAP  = 16'hC023;
	localparam logic [15:0] ID_CHAP = 16'hC223;
	localparam logic [15:0] ID_IPCP = 16'h8021;

	// Downlink containers with a two-octet length
	localparam logic [15:0] ID_WIDE_A = 16'h0023;
	localparam logic [15:0] ID_WIDE_B = 16'h0024;
	localparam logic [15:0] ID_WIDE_C = 16'h0030;

	// Role of one octet in the stream, decided by the front end
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_ID_HI    = 3'd0;
	localparam kind_t KIND_ID_LO    = 3'd1;
	localparam kind_t KIND_LEN_HI   = 3'd2;
	localparam kind_t KIND_LEN_LAST = 3'd3;
	localparam kind_t KIND_CONTENT  = 3'd4;

	// One classified octet, front end to back end
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        done;
		logic        trunc;
	} entry_t;

	function automatic logic proto_ident(input logic [15:0] id);
		return (id == ID_LCP) || (id == ID_PAP) || (id == ID_CHAP) || (id == ID_IPCP);
	endfunction

	function automatic logic wide_ident(input logic [15:0] id);
		return (id == ID_WIDE_A) || (id == ID_WIDE_B) || (id == ID_WIDE_C);
	endfunction

endpackage

// File: hw/rtl/pco_tlv_if.sv
// ----------------------------------------------------------------------------
// pco_tlv interfaces
// Valid/ready channels for the input octets, the results and the
// configuration register write.
// ----------------------------------------------------------------------------
interface pco_tlv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       buffer_end;

	modport source (output valid, stream_byte, buffer_end, input ready);
	modport sink   (input valid, stream_byte, buffer_end, output ready);
endinterface

interface pco_tlv_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] item_id;
	logic        protocol_list;
	logic [15:0] item_length;
	logic [7:0]  content_byte;
	logic        content_valid;
	logic        item_begin;
	logic        item_done;
	logic        truncated;

	modport source (output valid, item_id, protocol_list, item_length, content_byte,
		content_valid, item_begin, item_done, truncated, input ready);
	modport sink   (input valid, item_id, protocol_list, item_length, content_byte,
		content_valid, item_begin, item_done, truncated, output ready);
endinterface

interface pco_tlv_cfg_if;
	logic valid;
	logic ready;
	logic uplink_mode;

	modport source (output valid, uplink_mode, input ready);
	modport sink   (input valid, uplink_mode, output ready);
endinterface

// File: hw/rtl/pco_tlv_front.sv
// ----------------------------------------------------------------------------
// pco_tlv_front
// Item framing state machine: tracks the parse phase and the remaining
// content count, and tags every accepted octet with its role.
// ----------------------------------------------------------------------------
module pco_tlv_front
	import pco_tlv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic [7:0] in_byte,
	input  logic   in_last,
	input  logic   cfg_valid,
	input  logic   cfg_uplink,
	input  logic   q_full,
	output logic   push,
	output entry_t push_entry
);

	localparam logic [2:0] PH_ID_HI    = 3'd0;
	localparam logic [2:0] PH_ID_LO    = 3'd1;
	localparam logic [2:0] PH_LEN_HI   = 3'd2;
	localparam logic [2:0] PH_LEN_LAST = 3'd3;
	localparam logic [2:0] PH_CONTENT  = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic        uplink_q;
	logic [7:0]  idhi_q, idhi_d;
	logic [7:0]  lenhi_q, lenhi_d;
	logic [15:0] left_q, left_d;
	logic [15:0] id_full;
	logic [15:0] len_full;
	logic [15:0] left_dec;
	kind_t       kind;
	logic        done;

	assign in_ready = ~q_full;
	assign push     = in_valid & in_ready;

	assign id_full  = {idhi_q, in_byte};
	assign len_full = {lenhi_q, in_byte};
	assign left_dec = left_q - 16'd1;

	always_comb begin
		phase_d = phase_q;
		idhi_d  = idhi_q;
		lenhi_d = lenhi_q;
		left_d  = left_q;
		kind    = KIND_ID_HI;
		done    = 1'b0;
		case (phase_q)
			PH_ID_LO: begin
				kind = KIND_ID_LO;
				if (!proto_ident(id_full) && !uplink_q && wide_ident(id_full))
					phase_d = PH_LEN_HI;
				else
					phase_d = PH_LEN_LAST;
			end
			PH_LEN_HI: begin
				kind    = KIND_LEN_HI;
				lenhi_d = in_byte;
				phase_d = PH_LEN_LAST;
			end
			PH_LEN_LAST: begin
				kind   = KIND_LEN_LAST;
				left_d = len_full;
				if (len_full == 16'd0) begin
					done    = 1'b1;
					phase_d = PH_ID_HI;
				end else begin
					phase_d = PH_CONTENT;
				end
			end
			PH_CONTENT: begin
				kind   = KIND_CONTENT;
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					done    = 1'b1;
					phase_d = PH_ID_HI;
				end
			end
			default: begin
				// identifier high octet; unused codes land here too
				kind    = KIND_ID_HI;
				idhi_d  = in_byte;
				lenhi_d = 8'd0;
				left_d  = 16'd0;
				phase_d = PH_ID_LO;
			end
		endcase
		if (in_last)
			phase_d = PH_ID_HI;
	end

	assign push_entry.kind  = kind;
	assign push_entry.data  = in_byte;
	assign push_entry.done  = done;
	assign push_entry.trunc = in_last & ~done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ID_HI;
			uplink_q <= 1'b0;
		end else begin
			if (push)
				phase_q <= phase_d;
			if (cfg_valid)
				uplink_q <= cfg_uplink;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			idhi_q  <= idhi_d;
			lenhi_q <= lenhi_d;
			left_q  <= left_d;
		end
	end

endmodule

// File: hw/rtl/pco_tlv_queue.sv
// ----------------------------------------------------------------------------
// pco_tlv_queue
// Small register FIFO between the framing front end and the result back end.
// ----------------------------------------------------------------------------
module pco_tlv_queue
	import pco_tlv_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	output logic   pop_valid,
	input  logic   pop,
	output entry_t pop_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// File: hw/rtl/pco_tlv_back.sv
// ----------------------------------------------------------------------------
// pco_tlv_back
// Result builder: keeps the current identifier, list and length, and forms
// one result per classified octet into the output register.
// ----------------------------------------------------------------------------
module pco_tlv_back
	import pco_tlv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	output logic   pop,
	input  entry_t q_entry,
	pco_tlv_out_if.source tx
);

	logic        out_valid_q;
	logic [15:0] id_q, id_d;
	logic        proto_q, proto_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  lenhi_q, lenhi_d;
	logic [7:0]  cbyte;
	logic        cvalid;
	logic        begin_f;

	logic [15:0] o_id_q;
	logic        o_proto_q;
	logic [15:0] o_len_q;
	logic [7:0]  o_cbyte_q;
	logic        o_cvalid_q;
	logic        o_begin_q;
	logic        o_done_q;
	logic        o_trunc_q;

	// output register refills whenever it is empty or being drained
	assign pop = q_valid & (~out_valid_q | tx.ready);

	always_comb begin
		id_d    = id_q;
		proto_d = proto_q;
		len_d   = len_q;
		lenhi_d = lenhi_q;
		cbyte   = 8'd0;
		cvalid  = 1'b0;
		begin_f = 1'b0;
		case (q_entry.kind)
			KIND_ID_HI: begin
				id_d    = {q_entry.data, 8'd0};
				proto_d = 1'b0;
				len_d   = 16'd0;
				lenhi_d = 8'd0;
				begin_f = 1'b1;
			end
			KIND_ID_LO: begin
				id_d    = {id_q[15:8], q_entry.data};
				proto_d = proto_ident({id_q[15:8], q_entry.data});
			end
			KIND_LEN_HI:   lenhi_d = q_entry.data;
			KIND_LEN_LAST: len_d   = {lenhi_q, q_entry.data};
			KIND_CONTENT: begin
				cbyte  = q_entry.data;
				cvalid = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (tx.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			id_q       <= id_d;
			proto_q    <= proto_d;
			len_q      <= len_d;
			lenhi_q    <= lenhi_d;
			o_id_q     <= id_d;
			o_proto_q  <= proto_d;
			o_len_q    <= len_d;
			o_cbyte_q  <= cbyte;
			o_cvalid_q <= cvalid;
			o_begin_q  <= begin_f;
			o_done_q   <= q_entry.done;
			o_trunc_q  <= q_entry.trunc;
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.item_id       = o_id_q;
	assign tx.protocol_list = o_proto_q;
	assign tx.item_length   = o_len_q;
	assign tx.content_byte  = o_cbyte_q;
	assign tx.content_valid = o_cvalid_q;
	assign tx.item_begin    = o_begin_q;
	assign tx.item_done     = o_done_q;
	assign tx.truncated     = o_trunc_q;

endmodule

// File: hw/rtl/pco_tlv_stream_parser_core.sv
// ----------------------------------------------------------------------------
// pco_tlv_stream_parser_core
// Protocol configuration options item parser, one octet per request.
// ----------------------------------------------------------------------------
// Channels:
//   rx  - one buffer octet per request, with buffer_end on the final octet.
//   tx  - one result per input octet: item identifier, list, length, content
//         octet and the begin/done/truncated marks.
//   cfg - writes uplink_mode; write only while the parser is idle.
// Throughput: one octet per cycle sustained while tx keeps up. The framing
// state machine in the front end updates once per accepted octet, so
// consecutive octets follow each other with no gap until the queue fills.
// Path: an accepted rx octet is held in a queue slot, then in the output
// register, before it shows on tx.
// Reset: parser expects an identifier high octet, uplink_mode is 0, the
// queue and output register are empty.
// Stall: when tx is held off the queue fills; rx.ready falls once
// QUEUE_DEPTH octets are waiting and rises as soon as a slot frees.
// ----------------------------------------------------------------------------
module pco_tlv_stream_parser_core
	import pco_tlv_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	pco_tlv_in_if.sink    rx,
	pco_tlv_cfg_if.sink   cfg,
	pco_tlv_out_if.source tx
);

	entry_t push_entry;
	entry_t pop_entry;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_valid;

	assign cfg.ready = 1'b1;

	pco_tlv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rx.valid),
		.in_ready   (rx.ready),
		.in_byte    (rx.stream_byte),
		.in_last    (rx.buffer_end),
		.cfg_valid  (cfg.valid),
		.cfg_uplink (cfg.uplink_mode),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	pco_tlv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop_valid  (q_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	pco_tlv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.pop     (pop),
		.q_entry (pop_entry),
		.tx      (tx)
	);

endmodule

// File: hw/rtl/pco_tlv_checker.sv
// ----------------------------------------------------------------------------
// pco_tlv_checker
// Port-level checks on the result channel of the PCO item parser.
// ----------------------------------------------------------------------------
module pco_tlv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tx_valid,
	input logic        tx_ready,
	input logic [15:0] tx_item_id,
	input logic        tx_protocol_list,
	input logic [15:0] tx_item_length,
	input logic [7:0]  tx_content_byte,
	input logic        tx_content_valid,
	input logic        tx_item_begin,
	input logic        tx_item_done,
	input logic        tx_truncated
);

	// stalled result must hold its valid, identifier, done mark and content octet
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_item_id)
			&& $stable(tx_item_done) && $stable(tx_content_byte))
		else $error("tx result changed while stalled");

	a_done_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> !(tx_item_done && tx_truncated))
		else $error("item both done and truncated");

	a_cbyte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_content_valid |-> tx_content_byte == 8'd0)
		else $error("content octet without content_valid");

	// first identifier octet knows nothing beyond the high byte
	a_begin_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_item_begin |-> !tx_content_valid && !tx_protocol_list
			&& tx_item_length == 16'd0 && tx_item_id[7:0] == 8'd0 && !tx_item_done)
		else $error("item begin carries stale fields");

endmodule

bind pco_tlv_stream_parser_core pco_tlv_checker u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.tx_valid         (tx.valid),
	.tx_ready         (tx.ready),
	.tx_item_id       (tx.item_id),
	.tx_protocol_list (tx.protocol_list),
	.tx_item_length   (tx.item_length),
	.tx_content_byte  (tx.content_byte),
	.tx_content_valid (tx.content_valid),
	.tx_item_begin    (tx.item_begin),
	.tx_item_done     (tx.item_done),
	.tx_truncated     (tx.truncated)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCO item parser. Directed buffers cover the
// framing corner cases, then random buffers (mostly well-formed, some cut
// short, some noise) run under both uplink settings. Every accepted octet is
// predicted by a tracker object and each result is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pco_tlv_pkg::*;

	localparam int HOLD_CYCLES  = 64;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_OCTETS = 160;

	typedef struct packed {
		logic [15:0] item_id;
		logic        protocol_list;
		logic [15:0] item_length;
		logic [7:0]  content_byte;
		logic        content_valid;
		logic        item_begin;
		logic        item_done;
		logic        truncated;
	} result_t;

	class tlv_parse_tracker;
		bit          uplink;
		kind_t       phase;
		logic [15:0] cur_id;
		logic [15:0] cur_len;
		logic [15:0] left;
		logic        proto;
		result_t     pending_results[$];
		int unsigned errors;

		function new();
			uplink  = 1'b0;
			phase   = KIND_ID_HI;
			cur_id  = '0;
			cur_len = '0;
			left    = '0;
			proto   = 1'b0;
			errors  = 0;
		endfunction

		function string fmt(result_t r);
			return $sformatf("id=%h proto=%b len=%h byte=%h cv=%b begin=%b done=%b trunc=%b",
				r.item_id, r.protocol_list, r.item_length, r.content_byte,
				r.content_valid, r.item_begin, r.item_done, r.truncated);
		endfunction

		function void note_octet(logic [7:0] b, logic last);
			result_t r;
			r = '0;
			case (phase)
				KIND_ID_LO: begin
					cur_id[7:0] = b;
					proto = (cur_id == ID_LCP) || (cur_id == ID_PAP) ||
						(cur_id == ID_CHAP) || (cur_id == ID_IPCP);
					// two-octet length only for downlink containers
					if (!proto && !uplink && ((cur_id == ID_WIDE_A) ||
						(cur_id == ID_WIDE_B) || (cur_id == ID_WIDE_C)))
						phase = KIND_LEN_HI;
					else
						phase = KIND_LEN_LAST;
				end
				KIND_LEN_HI: begin
					left  = {b, 8'h00};
					phase = KIND_LEN_LAST;
				end
				KIND_LEN_LAST: begin
					cur_len = {left[15:8], b};
					left    = cur_len;
					if (cur_len == 16'd0) begin
						r.item_done = 1'b1;
						phase = KIND_ID_HI;
					end else begin
						phase = KIND_CONTENT;
					end
				end
				KIND_CONTENT: begin
					r.content_byte  = b;
					r.content_valid = 1'b1;
					left = left - 16'd1;
					if (left == 16'd0) begin
						r.item_done = 1'b1;
						phase = KIND_ID_HI;
					end
				end
				default: begin
					cur_id       = {b, 8'h00};
					cur_len      = '0;
					left         = '0;
					proto        = 1'b0;
					r.item_begin = 1'b1;
					phase        = KIND_ID_LO;
				end
			endcase
			if (last) begin
				r.truncated = !r.item_done;
				phase = KIND_ID_HI;
			end
			r.item_id       = cur_id;
			r.protocol_list = proto;
			r.item_length   = cur_len;
			pending_results = {pending_results, r};
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: %s", fmt(got));
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: expected %s", fmt(want));
					$display("          actual   %s", fmt(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pco_tlv_in_if  rx_if ();
	pco_tlv_out_if tx_if ();
	pco_tlv_cfg_if cfg_if ();

	pco_tlv_stream_parser_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if),
		.cfg   (cfg_if),
		.tx    (tx_if)
	);

	tlv_parse_tracker tracker = new();

	logic [15:0] proto_ids [4] = '{ID_LCP, ID_PAP, ID_CHAP, ID_IPCP};
	logic [15:0] wide_ids [3]  = '{ID_WIDE_A, ID_WIDE_B, ID_WIDE_C};

	int unsigned octets_sent = 0;
	int unsigned burst_left  = 0;
	int unsigned idle_cycles = 0;
	bit          hold_req    = 1'b0;

	always #1 clk = ~clk;

	// sender: bursts of random length, random gaps, none while tx is held off
	task automatic send_octet(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = hold_req ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				rx_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		rx_if.valid       <= 1'b1;
		rx_if.stream_byte <= b;
		rx_if.buffer_end  <= last;
		do @(posedge clk); while (!rx_if.ready);
		tracker.note_octet(b, last);
		octets_sent++;
	endtask

	task automatic send_buffer(input logic [7:0] octets[$]);
		foreach (octets[i])
			send_octet(octets[i], i == octets.size() - 1);
	endtask

	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_uplink(input logic mode);
		cfg_if.valid       <= 1'b1;
		cfg_if.uplink_mode <= mode;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		tracker.uplink = mode;
	endtask

	function automatic void add_item(ref logic [7:0] q[$], input bit up);
		logic [15:0] id;
		bit          wide;
		int          len;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: id = proto_ids[$urandom_range(0, 3)];
			4, 5, 6:    id = wide_ids[$urandom_range(0, 2)];
			default:    id = 16'($urandom);
		endcase
		wide = !up && ((id == ID_WIDE_A) || (id == ID_WIDE_B) || (id == ID_WIDE_C));
		if (wide)
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 320) : $urandom_range(0, 8);
		else
			case ($urandom_range(0, 19))
				0:       len = 255;
				1:       len = $urandom_range(0, 255);
				default: len = $urandom_range(0, 8);
			endcase
		q = {q, id[15:8]};
		q = {q, id[7:0]};
		if (wide)
			q = {q, 8'(len >> 8)};
		q = {q, 8'(len)};
		repeat (len) q = {q, 8'($urandom)};
	endfunction

	task automatic send_random_buffer();
		logic [7:0] octets[$];
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 88) begin
			repeat ($urandom_range(1, 4)) add_item(octets, tracker.uplink);
			// cut short so the buffer can end inside an item
			if (sel >= 75 && octets.size() > 1)
				repeat ($urandom_range(1, octets.size() - 1)) void'(octets.pop_back());
		end else begin
			repeat ($urandom_range(1, 12)) octets = {octets, 8'($urandom)};
		end
		send_buffer(octets);
	endtask

	// receiver: random ready with a changing stall percentage (0, 30 or 70), one long hold-off
	initial begin
		int stall_pct;
		int pattern_left;
		stall_pct    = 0;
		pattern_left = 0;
		forever begin
			if (hold_req) begin
				tx_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (pattern_left == 0) begin
					case ($urandom_range(0, 2))
						0:       stall_pct = 0;
						1:       stall_pct = 30;
						default: stall_pct = 70;
					endcase
					pattern_left = $urandom_range(20, 80);
				end
				pattern_left--;
				tx_if.ready <= ($urandom_range(0, 99) >= stall_pct);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && tx_if.valid && tx_if.ready)
			tracker.check_result('{tx_if.item_id, tx_if.protocol_list, tx_if.item_length,
				tx_if.content_byte, tx_if.content_valid, tx_if.item_begin,
				tx_if.item_done, tx_if.truncated});
	end

	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) ||
			(cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		logic [7:0] octets[$];
		int unsigned phase_start;
		arst_n             <= 1'b0;
		rx_if.valid        <= 1'b0;
		rx_if.stream_byte  <= '0;
		rx_if.buffer_end   <= 1'b0;
		cfg_if.valid       <= 1'b0;
		cfg_if.uplink_mode <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_uplink(1'b0);
		// protocol item, zero-length wide container, wide container ending the buffer
		octets = '{8'hC0, 8'h21, 8'h01, 8'hAA, 8'h00, 8'h23, 8'h00, 8'h00,
			8'h00, 8'h30, 8'h00, 8'h02, 8'hFF, 8'h00};
		send_buffer(octets);
		// zero-length item completing on the final octet
		octets = '{8'hFF, 8'hFF, 8'h00};
		send_buffer(octets);
		// buffer ends in the content
		octets = '{8'h80, 8'h21, 8'h05, 8'h11};
		send_buffer(octets);
		// buffer ends on the first identifier octet
		octets = '{8'h00};
		send_buffer(octets);
		wait_drained();
		write_uplink(1'b1);
		// container id takes a one-octet length in uplink
		octets = '{8'h00, 8'h24, 8'h00};
		send_buffer(octets);

		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			write_uplink(ph[0] ? 1'b0 : 1'b1);
			phase_start = octets_sent;
			while (octets_sent - phase_start < PHASE_OCTETS) begin
				if (ph == 1 && octets_sent - phase_start == 0) begin
					send_random_buffer();
					hold_req = 1'b1;
					while (hold_req) send_random_buffer();
				end else begin
					send_random_buffer();
				end
			end
		end

		wait_drained();
		repeat (6) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/pco_tlv_pkg.sv
hw/rtl/pco_tlv_if.sv
hw/rtl/pco_tlv_front.sv
hw/rtl/pco_tlv_queue.sv
hw/rtl/pco_tlv_back.sv
hw/rtl/pco_tlv_stream_parser_core.sv
hw/rtl/pco_tlv_checker.sv
sim/tb_top.sv
